@@ hw/rtl/qte_pkg.sv @@
package qte_pkg;

    localparam int CORDIC_STEPS = 16;

    // cordic datapath: x/y carry growth of the rotation, z is radians with 24 fraction bits
    localparam int CW = 36;
    localparam int ZW = 28;
    localparam int AW = 30;

    // square root: 63-bit radicand, one result bit per stage
    localparam int SQ_W     = 63;
    localparam int SQ_STEPS = 32;
    localparam int ROOT_W   = 32;

    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [AW-1:0] PI_Q24      = 30'sd52707179;
    localparam logic signed [AW-1:0] TWO_PI_Q24  = 30'sd105414357;
    localparam logic signed [14:0]   HALF_PI_Q13 = 15'sd12868;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } t_pole;

    typedef struct packed {
        logic                 valid;
        t_pole                pole;
        logic signed [CW-1:0] yaw_x;
        logic signed [CW-1:0] yaw_y;
        logic signed [CW-1:0] roll_x;
        logic signed [CW-1:0] roll_y;
        logic signed [31:0]   sin_arg;
    } t_side;

    typedef struct packed {
        logic  valid;
        t_pole pole;
    } t_tag;

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] res;
        case (i)
            0:       res = 28'sd13176795;
            1:       res = 28'sd7778716;
            2:       res = 28'sd4110060;
            3:       res = 28'sd2086331;
            4:       res = 28'sd1047214;
            5:       res = 28'sd524117;
            6:       res = 28'sd262123;
            7:       res = 28'sd131069;
            8:       res = 28'sd65536;
            default: res = ZW'(32'sd1 <<< (24 - i));
        endcase
        return res;
    endfunction

endpackage

@@ hw/rtl/qte_front.sv @@
module qte_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [15:0]            i_w,
    input  logic signed [15:0]            i_x,
    input  logic signed [15:0]            i_y,
    input  logic signed [15:0]            i_z,
    output qte_pkg::t_side                o_side,
    output logic [qte_pkg::SQ_W-1:0]      o_rad
);
    import qte_pkg::*;

    // stage 1: products
    logic               r1_valid;
    logic signed [31:0] r1_ww, r1_xx, r1_yy, r1_zz, r1_xw, r1_yz, r1_wy, r1_zx, r1_wz, r1_xy;
    logic signed [15:0] r1_x, r1_y;

    // stage 2: sums
    logic               r2_valid;
    logic signed [33:0] r2_unit;
    logic signed [32:0] r2_test;
    logic signed [33:0] r2_yaw_x, r2_yaw_y, r2_roll_x, r2_roll_y;
    logic signed [31:0] r2_s;
    logic signed [15:0] r2_x, r2_y;
    logic signed [33:0] n2_unit, n2_yaw_x, n2_yaw_y, n2_roll_x, n2_roll_y, n2_t2;
    logic signed [32:0] n2_test;
    logic signed [31:0] n2_s;

    // stage 3: pole products and s squared
    logic               r3_valid;
    logic signed [47:0] r3_pt, r3_pu;
    logic signed [63:0] r3_ss;
    logic signed [33:0] r3_yaw_x, r3_yaw_y, r3_roll_x, r3_roll_y;
    logic signed [31:0] r3_s;
    logic signed [15:0] r3_x, r3_y;
    logic signed [63:0] n3_ss;

    // stage 4: pole decision and radicand
    t_side              r4_side, n4_side;
    logic [SQ_W-1:0]    r4_rad, n4_rad;
    logic [63:0]        n4_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ww <= i_w * i_w;
            r1_xx <= i_x * i_x;
            r1_yy <= i_y * i_y;
            r1_zz <= i_z * i_z;
            r1_xw <= i_x * i_w;
            r1_yz <= i_y * i_z;
            r1_wy <= i_w * i_y;
            r1_zx <= i_z * i_x;
            r1_wz <= i_w * i_z;
            r1_xy <= i_x * i_y;
            r1_x  <= i_x;
            r1_y  <= i_y;
        end
    end

    always_comb begin
        n2_unit   = 34'(r1_ww) + 34'(r1_xx) + 34'(r1_yy) + 34'(r1_zz);
        n2_test   = 33'(r1_xw) - 33'(r1_yz);
        n2_yaw_y  = (34'(r1_wy) + 34'(r1_zx)) <<< 1;
        n2_yaw_x  = 34'sh0_4000_0000 - ((34'(r1_xx) + 34'(r1_yy)) <<< 1);
        n2_roll_y = (34'(r1_wz) + 34'(r1_xy)) <<< 1;
        n2_roll_x = 34'sh0_4000_0000 - ((34'(r1_xx) + 34'(r1_zz)) <<< 1);
        n2_t2     = 34'(n2_test) <<< 1;
        // asin argument saturates to plus or minus one
        priority if (n2_t2 > 34'sh0_4000_0000) begin
            n2_s = 32'sh4000_0000;
        end else if (n2_t2 < -34'sh0_4000_0000) begin
            n2_s = -32'sh4000_0000;
        end else begin
            n2_s = 32'(n2_t2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_unit   <= n2_unit;
            r2_test   <= n2_test;
            r2_yaw_x  <= n2_yaw_x;
            r2_yaw_y  <= n2_yaw_y;
            r2_roll_x <= n2_roll_x;
            r2_roll_y <= n2_roll_y;
            r2_s      <= n2_s;
            r2_x      <= r1_x;
            r2_y      <= r1_y;
        end
    end

    assign n3_ss = r2_s * r2_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pt     <= 48'(r2_test) * 48'sd10000;
            r3_pu     <= 48'(r2_unit) * 48'sd4995;
            r3_ss     <= n3_ss;
            r3_yaw_x  <= r2_yaw_x;
            r3_yaw_y  <= r2_yaw_y;
            r3_roll_x <= r2_roll_x;
            r3_roll_y <= r2_roll_y;
            r3_s      <= r2_s;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
        end
    end

    always_comb begin
        n4_side.valid   = r3_valid;
        n4_side.roll_x  = CW'(r3_roll_x);
        n4_side.roll_y  = CW'(r3_roll_y);
        n4_side.sin_arg = r3_s;
        priority if (r3_pt > r3_pu) begin
            n4_side.pole = POLE_NORTH;
        end else if (r3_pt < -r3_pu) begin
            n4_side.pole = POLE_SOUTH;
        end else begin
            n4_side.pole = POLE_NONE;
        end
        // at a pole yaw comes from atan2(y, x) of the raw components
        if (n4_side.pole != POLE_NONE) begin
            n4_side.yaw_x = CW'(r3_x) <<< 15;
            n4_side.yaw_y = CW'(r3_y) <<< 15;
        end else begin
            n4_side.yaw_x = CW'(r3_yaw_x);
            n4_side.yaw_y = CW'(r3_yaw_y);
        end
        n4_diff = 64'h1000_0000_0000_0000 - 64'(r3_ss);
        n4_rad  = n4_diff[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side.valid <= 1'b0;
        end else if (i_en) begin
            r4_side <= n4_side;
            r4_rad  <= n4_rad;
        end
    end

    assign o_side = r4_side;
    assign o_rad  = r4_rad;

endmodule

@@ hw/rtl/qte_sqrt.sv @@
module qte_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  qte_pkg::t_side              i_side,
    input  logic [qte_pkg::SQ_W-1:0]    i_rad,
    output qte_pkg::t_side              o_side,
    output logic [qte_pkg::ROOT_W-1:0]  o_root
);
    import qte_pkg::*;

    t_side           r_side [SQ_STEPS];
    logic [SQ_W-1:0] r_v [SQ_STEPS];
    logic [SQ_W-1:0] r_r [SQ_STEPS];
    logic [SQ_W-1:0] n_v [SQ_STEPS];
    logic [SQ_W-1:0] n_r [SQ_STEPS];
    logic [SQ_W-1:0] c_v [SQ_STEPS];
    logic [SQ_W-1:0] c_r [SQ_STEPS];
    logic [SQ_W-1:0] c_b [SQ_STEPS];
    logic [SQ_W-1:0] c_t [SQ_STEPS];

    // one result bit per stage, trial bit walks down two places each stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                c_v[k] = i_rad;
                c_r[k] = '0;
            end else begin
                c_v[k] = r_v[k-1];
                c_r[k] = r_r[k-1];
            end
            c_b[k] = SQ_W'(1) << (SQ_W - 1 - 2 * k);
            c_t[k] = c_r[k] + c_b[k];
            if (c_v[k] >= c_t[k]) begin
                n_v[k] = c_v[k] - c_t[k];
                n_r[k] = (c_r[k] >> 1) + c_b[k];
            end else begin
                n_v[k] = c_v[k];
                n_r[k] = c_r[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_v[k]    <= n_v[k];
                r_r[k]    <= n_r[k];
            end
        end
    end

    assign o_side = r_side[SQ_STEPS-1];
    assign o_root = r_r[SQ_STEPS-1][ROOT_W-1:0];

endmodule

@@ hw/rtl/qte_cordic.sv @@
module qte_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [qte_pkg::CW-1:0] i_x,
    input  logic signed [qte_pkg::CW-1:0] i_y,
    output logic signed [qte_pkg::ZW-1:0] o_ang
);
    import qte_pkg::*;

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic                 r_zero [CORDIC_STEPS+1];
    logic signed [CW-1:0] n_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] n_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] n_z [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_xs [CORDIC_STEPS];
    logic signed [CW-1:0] c_ys [CORDIC_STEPS];

    always_comb begin
        // left half plane is rotated by a quarter turn first
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x[0] = i_y;
                n_y[0] = -i_x;
                n_z[0] = HALF_PI_Q24;
            end else begin
                n_x[0] = -i_y;
                n_y[0] = i_x;
                n_z[0] = -HALF_PI_Q24;
            end
        end else begin
            n_x[0] = i_x;
            n_y[0] = i_y;
            n_z[0] = '0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            c_xs[i] = r_x[i] >>> i;
            c_ys[i] = r_y[i] >>> i;
            if (r_y[i] >= 0) begin
                n_x[i+1] = r_x[i] + c_ys[i];
                n_y[i+1] = r_y[i] - c_xs[i];
                n_z[i+1] = r_z[i] + atan_step(i);
            end else begin
                n_x[i+1] = r_x[i] - c_ys[i];
                n_y[i+1] = r_y[i] + c_xs[i];
                n_z[i+1] = r_z[i] - atan_step(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == 0 && i_y == 0);
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_z[i]    <= n_z[i];
            end
            for (int i = 1; i <= CORDIC_STEPS; i++) begin
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // atan2 of the zero vector is zero
    assign o_ang = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// quaternion to yaw / pitch / roll, one item per cycle while the output is not stalled
// pipeline: 4 front stages, 32 square root stages, CORDIC_STEPS + 1 cordic stages,
// one output register
// throughput: one item per cycle; a stall at the output freezes the whole pipeline
// reset: synchronous active low, clears the valid bits only
module quaternion_to_euler_angles (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle,
    output logic [1:0]         o_pole_case
);
    import qte_pkg::*;

    localparam int TAG_LAT = CORDIC_STEPS + 1;

    logic              en;
    t_side             f_side, s_side;
    logic [SQ_W-1:0]   f_rad;
    logic [ROOT_W-1:0] s_root;
    logic signed [ZW-1:0] yaw_z, roll_z, pitch_z;
    t_tag              r_tag [TAG_LAT];

    logic signed [AW-1:0] n_yaw_a, n_yaw_r, n_roll_r, n_pitch_r;
    logic signed [15:0]   n_yaw, n_roll;
    logic signed [14:0]   n_pitch;

    logic               r_valid;
    t_pole              r_pole;
    logic signed [15:0] r_yaw, r_roll;
    logic signed [14:0] r_pitch;

    function automatic logic signed [AW-1:0] wrap_round(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] w;
        priority if (a > PI_Q24) begin
            w = a - TWO_PI_Q24;
        end else if (a < -PI_Q24) begin
            w = a + TWO_PI_Q24;
        end else begin
            w = a;
        end
        return (w + AW'(1024)) >>> 11;
    endfunction

    assign en      = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    qte_cordic u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (s_side.yaw_x),
        .i_y   (s_side.yaw_y),
        .o_ang (yaw_z)
    );

    qte_cordic u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (s_side.roll_x),
        .i_y   (s_side.roll_y),
        .o_ang (roll_z)
    );

    // pitch = atan2(s, sqrt(1 - s^2))
    qte_cordic u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed({{(CW - ROOT_W){1'b0}}, s_root})),
        .i_y   (CW'(s_side.sin_arg)),
        .o_ang (pitch_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAG_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_tag[0] <= t_tag'{valid: s_side.valid, pole: s_side.pole};
            for (int k = 1; k < TAG_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_comb begin
        unique case (r_tag[TAG_LAT-1].pole)
            POLE_NORTH: n_yaw_a = AW'(yaw_z) <<< 1;
            POLE_SOUTH: n_yaw_a = -(AW'(yaw_z) <<< 1);
            default:    n_yaw_a = AW'(yaw_z);
        endcase
        n_yaw_r   = wrap_round(n_yaw_a);
        n_roll_r  = wrap_round(AW'(roll_z));
        n_pitch_r = wrap_round(AW'(pitch_z));
        n_yaw     = n_yaw_r[15:0];
        unique case (r_tag[TAG_LAT-1].pole)
            POLE_NORTH: begin
                n_roll  = '0;
                n_pitch = HALF_PI_Q13;
            end
            POLE_SOUTH: begin
                n_roll  = '0;
                n_pitch = -HALF_PI_Q13;
            end
            default: begin
                n_roll = n_roll_r[15:0];
                priority if (n_pitch_r > AW'(HALF_PI_Q13)) begin
                    n_pitch = HALF_PI_Q13;
                end else if (n_pitch_r < -AW'(HALF_PI_Q13)) begin
                    n_pitch = -HALF_PI_Q13;
                end else begin
                    n_pitch = n_pitch_r[14:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= r_tag[TAG_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pole  <= r_tag[TAG_LAT-1].pole;
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
            r_roll  <= n_roll;
        end
    end

    assign o_valid       = r_valid;
    assign o_yaw_angle   = r_yaw;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;
    assign o_pole_case   = r_pole;

    a_pole_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case != 2'(POLE_NONE) |-> o_roll_angle == 16'sd0)
        else $error("roll not zero at a pole");

    a_north_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case == 2'(POLE_NORTH) |-> o_pitch_angle == HALF_PI_Q13)
        else $error("north pole pitch wrong");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_angle <= HALF_PI_Q13 && o_pitch_angle >= -HALF_PI_Q13)
        else $error("pitch out of range");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("output stall not passed back");

endmodule
